@@ design/kvi_pkg.sv @@
// Shared types, constants and the cosine ease weight table for the keyframe interpolator.
`timescale 1ns / 1ps

package kvi_pkg;

    localparam int WEIGHT_TABLE_BITS = 10;
    localparam int FRAC_W      = 17;
    localparam int VALUE_W     = 32;
    localparam int DIFF_W      = 34;
    localparam int PROD1_W     = 51;
    localparam int SUM_W       = 52;
    localparam int PROD2_W     = 70;
    localparam int ACC_W       = 64;
    localparam int TABLE_SHIFT = 16 - WEIGHT_TABLE_BITS;
    localparam int TABLE_DEPTH = (1 << WEIGHT_TABLE_BITS) + 1;
    localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

    localparam logic [FRAC_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [FRAC_W-1:0] HALF_Q16  = 17'h08000;
    localparam longint            ONE_Q30   = 64'sd1073741824;
    localparam logic [63:0]       PI_Q30    = 64'd3373259426;
    localparam logic [ACC_W-1:0]  ROUND_BIAS = 64'h0000_0000_8000_0000;

    // Horner divisors 2^30 * k, innermost step first
    localparam longint HORNER_D0 = ONE_Q30 * 64'sd182;
    localparam longint HORNER_D1 = ONE_Q30 * 64'sd132;
    localparam longint HORNER_D2 = ONE_Q30 * 64'sd90;
    localparam longint HORNER_D3 = ONE_Q30 * 64'sd56;
    localparam longint HORNER_D4 = ONE_Q30 * 64'sd30;
    localparam longint HORNER_D5 = ONE_Q30 * 64'sd12;
    localparam longint HORNER_D6 = ONE_Q30 * 64'sd2;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_LINEAR = 2'd1,
        MODE_COSINE = 2'd2,
        MODE_BEZIER = 2'd3
    } mode_t;

    // First stage beat handed to the blend pipeline
    typedef struct packed {
        mode_t                     mode;
        logic [FRAC_W-1:0]         frac;
        logic signed [VALUE_W-1:0] start;
        logic signed [DIFF_W-1:0]  slope;
        logic signed [DIFF_W-1:0]  curve;
    } st1_t;

    typedef logic [FRAC_W-1:0] ease_table_t [TABLE_DEPTH];

    // (1 - cos(pi*x)) / 2 for x in [0, 0.5], Q0.16 in and out
    function automatic logic [FRAC_W-1:0] half_ease(input logic [FRAC_W-1:0] x);
        logic [63:0] theta;
        logic [63:0] theta_sq;
        longint      t2;
        longint      h;
        longint      g;
        theta    = (PI_Q30 * 64'(x)) >> 16;
        theta_sq = theta * theta;
        t2       = longint'(theta_sq >> 30);
        h        = ONE_Q30;
        h        = ONE_Q30 - (t2 * h) / HORNER_D0;
        h        = ONE_Q30 - (t2 * h) / HORNER_D1;
        h        = ONE_Q30 - (t2 * h) / HORNER_D2;
        h        = ONE_Q30 - (t2 * h) / HORNER_D3;
        h        = ONE_Q30 - (t2 * h) / HORNER_D4;
        h        = ONE_Q30 - (t2 * h) / HORNER_D5;
        h        = ONE_Q30 - (t2 * h) / HORNER_D6;
        if (h < 0)
        begin
            h = 0;
        end
        if (h > ONE_Q30)
        begin
            h = ONE_Q30;
        end
        g = ((ONE_Q30 - h) + 64'sd16384) >>> 15;
        return FRAC_W'(g);
    endfunction

    function automatic logic [FRAC_W-1:0] ease_weight(input int idx);
        logic [FRAC_W-1:0] x;
        x = FRAC_W'(idx << TABLE_SHIFT);
        if (x <= HALF_Q16)
        begin
            return half_ease(x);
        end
        return ONE_Q16 - half_ease(ONE_Q16 - x);
    endfunction

    function automatic ease_table_t build_ease_table();
        ease_table_t t;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            t[i] = ease_weight(i);
        end
        return t;
    endfunction

endpackage

@@ design/kvi_ease_rom.sv @@
// Cosine ease weight ROM with registered read data.
`timescale 1ns / 1ps

module kvi_ease_rom (
    input  logic                             clk,
    input  logic [kvi_pkg::TABLE_IDX_W-1:0]  idx,
    output logic [kvi_pkg::FRAC_W-1:0]       weight
);

    localparam kvi_pkg::ease_table_t EASE_ROM = kvi_pkg::build_ease_table();

    logic [kvi_pkg::FRAC_W-1:0] weight_reg;

    always_ff @(posedge clk)
    begin
        weight_reg <= EASE_ROM[idx];
    end

    assign weight = weight_reg;

endmodule

@@ design/kvi_blend.sv @@
// Blend pipeline: weight select, curve product, sum, final product and rounding.
`timescale 1ns / 1ps

module kvi_blend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  kvi_pkg::st1_t                        st1,
    input  logic [kvi_pkg::FRAC_W-1:0]           ease,
    output logic signed [kvi_pkg::VALUE_W-1:0]   value,
    output logic                                 done
);

    // stage 2: curve term m * curve, outer weight
    logic                                  v2_reg;
    logic signed [kvi_pkg::PROD1_W-1:0]    p1_reg;
    logic signed [kvi_pkg::PROD1_W-1:0]    p1_next;
    logic [kvi_pkg::FRAC_W-1:0]            wt2_reg;
    logic [kvi_pkg::FRAC_W-1:0]            wt2_next;
    logic signed [kvi_pkg::DIFF_W-1:0]     slope2_reg;
    logic signed [kvi_pkg::VALUE_W-1:0]    start2_reg;
    logic signed [kvi_pkg::FRAC_W:0]       frac_s;
    logic signed [kvi_pkg::DIFF_W+kvi_pkg::FRAC_W:0] p1_full;

    // stage 3: inner sum
    logic                                  v3_reg;
    logic signed [kvi_pkg::SUM_W-1:0]      q_reg;
    logic signed [kvi_pkg::SUM_W-1:0]      q_next;
    logic [kvi_pkg::FRAC_W-1:0]            wt3_reg;
    logic signed [kvi_pkg::VALUE_W-1:0]    start3_reg;

    // stage 4: outer product
    logic                                  v4_reg;
    logic signed [kvi_pkg::ACC_W-1:0]      prod_reg;
    logic signed [kvi_pkg::PROD2_W-1:0]    prod_full;
    logic signed [kvi_pkg::VALUE_W-1:0]    start4_reg;
    logic signed [kvi_pkg::FRAC_W:0]       wt_s;

    // stage 5: round and add start
    logic                                  v5_reg;
    logic signed [kvi_pkg::VALUE_W-1:0]    value_reg;
    logic [kvi_pkg::ACC_W-1:0]             acc_next;

    always_comb
    begin
        frac_s  = $signed({1'b0, st1.frac});
        p1_full = frac_s * st1.curve;
        p1_next = kvi_pkg::PROD1_W'(p1_full);
        unique case (st1.mode)
            kvi_pkg::MODE_HOLD:   wt2_next = '0;
            kvi_pkg::MODE_LINEAR: wt2_next = st1.frac;
            kvi_pkg::MODE_COSINE: wt2_next = ease;
            kvi_pkg::MODE_BEZIER: wt2_next = st1.frac;
            default:              wt2_next = '0;
        endcase
    end

    assign q_next = (kvi_pkg::SUM_W'(slope2_reg) <<< 16) + kvi_pkg::SUM_W'(p1_reg);

    always_comb
    begin
        wt_s      = $signed({1'b0, wt3_reg});
        prod_full = wt_s * q_reg;
    end

    // true result fits 32 bits, so modulo 2^64 arithmetic is exact here
    assign acc_next = {start4_reg, 32'h0} + prod_reg + kvi_pkg::ROUND_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        wt2_reg    <= wt2_next;
        slope2_reg <= st1.slope;
        start2_reg <= st1.start;
        q_reg      <= q_next;
        wt3_reg    <= wt2_reg;
        start3_reg <= start2_reg;
        prod_reg   <= prod_full[kvi_pkg::ACC_W-1:0];
        start4_reg <= start3_reg;
        value_reg  <= acc_next[kvi_pkg::ACC_W-1:32];
    end

    assign value = value_reg;
    assign done  = v5_reg;

endmodule

@@ design/keyframe_value_interpolator.sv @@
// Top level of the keyframe value interpolator: input stage and pipeline wiring.
`timescale 1ns / 1ps

// Keyframe value interpolator.
// Command channel: drive mode, start_value, end_value, control_point and
// fraction with start high; the beat is taken at any edge where busy is low.
// busy stays low, so a new beat may be issued in every cycle.
// Result channel: value is shown for one cycle with done high, once the command
// has passed the five register stages, and is taken at the edge that ends that cycle.
// Results leave in command order.
// Throughput is one beat per cycle: five register stages (input capture with
// the ease ROM read, curve product, inner sum, outer product, rounding) each
// hold one beat, and no stage loops.
// Modes: hold start, linear, cosine ease from a 1025-entry weight ROM indexed
// by the top fraction bits, and quadratic Bezier through control_point.
// Fractions above one are clamped to one.
// Reset clears the valid bits of all stages; no done pulse follows reset
// until a new command is issued. Nothing is kept between beats.
// The receiver cannot stall; each result must be taken in its done cycle.
module keyframe_value_interpolator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [kvi_pkg::VALUE_W-1:0]  start_value,
    input  logic signed [kvi_pkg::VALUE_W-1:0]  end_value,
    input  logic signed [kvi_pkg::VALUE_W-1:0]  control_point,
    input  logic [kvi_pkg::FRAC_W-1:0]          fraction,
    output logic signed [kvi_pkg::VALUE_W-1:0]  value,
    output logic                                done
);

    logic                                 v1_reg;
    kvi_pkg::st1_t                        st1_reg;
    kvi_pkg::st1_t                        st1_next;
    logic [kvi_pkg::FRAC_W-1:0]           frac_sat;
    logic [kvi_pkg::TABLE_IDX_W-1:0]      rom_idx;
    logic [kvi_pkg::FRAC_W-1:0]           ease;
    logic signed [kvi_pkg::DIFF_W-1:0]    a_x;
    logic signed [kvi_pkg::DIFF_W-1:0]    b_x;
    logic signed [kvi_pkg::DIFF_W-1:0]    c_x;
    kvi_pkg::mode_t                       mode_in;

    assign busy = 1'b0;

    always_comb
    begin
        mode_in  = kvi_pkg::mode_t'(mode);
        frac_sat = (fraction > kvi_pkg::ONE_Q16) ? kvi_pkg::ONE_Q16 : fraction;
        rom_idx  = kvi_pkg::TABLE_IDX_W'(frac_sat >> kvi_pkg::TABLE_SHIFT);
        a_x      = kvi_pkg::DIFF_W'(start_value);
        b_x      = kvi_pkg::DIFF_W'(end_value);
        c_x      = kvi_pkg::DIFF_W'(control_point);

        st1_next.mode  = mode_in;
        st1_next.frac  = frac_sat;
        st1_next.start = start_value;
        // Bezier: 2^32*a + m*(2^17*(c-a) + m*(a-2c+b)); blends use curve = 0
        if (mode_in == kvi_pkg::MODE_BEZIER)
        begin
            st1_next.slope = (c_x - a_x) <<< 1;
            st1_next.curve = a_x - (c_x <<< 1) + b_x;
        end
        else
        begin
            st1_next.slope = b_x - a_x;
            st1_next.curve = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_reg <= st1_next;
    end

    kvi_ease_rom u_ease_rom (
        .clk    (clk),
        .idx    (rom_idx),
        .weight (ease)
    );

    kvi_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .st1      (st1_reg),
        .ease     (ease),
        .value    (value),
        .done     (done)
    );

endmodule

@@ tb/keyframe_value_interpolator_tb.sv @@
// Self-checking testbench for the keyframe value interpolator with a bit-exact blend predictor.
`timescale 1ns / 1ps

module keyframe_value_interpolator_tb;

    localparam int          TBL_SHIFT  = 16 - kvi_pkg::WEIGHT_TABLE_BITS;
    localparam longint      Q30_ONE    = 64'sd1073741824;
    localparam longint      PI_FIXED   = 64'sd3373259426;
    localparam logic [31:0] BIAS       = 32'h8000_0000;
    localparam logic [31:0] VAL_MIN    = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX    = 32'h7FFF_FFFF;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;
    localparam logic [16:0] FRAC_HALF  = 17'h08000;
    localparam logic [16:0] FRAC_TOP   = 17'h1FFFF;
    localparam int          DRAIN_CYC  = 12;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    kvi_pkg::mode_t                     mode;
    logic signed [kvi_pkg::VALUE_W-1:0] start_value;
    logic signed [kvi_pkg::VALUE_W-1:0] end_value;
    logic signed [kvi_pkg::VALUE_W-1:0] control_point;
    logic [kvi_pkg::FRAC_W-1:0]         fraction;
    logic signed [kvi_pkg::VALUE_W-1:0] value;
    logic                               done;

    logic signed [kvi_pkg::VALUE_W-1:0] pending_values [$];
    int                                 mismatch_count;
    bit                                 idle_en;

    keyframe_value_interpolator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .start_value   (start_value),
        .end_value     (end_value),
        .control_point (control_point),
        .fraction      (fraction),
        .value         (value),
        .done          (done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // (1 - cos(pi*x)) / 2 for x in [0, 0.5], Q0.16, via a Horner series in Q2.30
    function automatic longint half_cosine(input longint x);
        longint theta;
        longint t2;
        longint h;
        longint divisor [7];
        divisor = '{182, 132, 90, 56, 30, 12, 2};
        theta = (PI_FIXED * x) >>> 16;
        t2    = (theta * theta) >>> 30;
        h     = Q30_ONE;
        for (int i = 0; i < 7; i++)
        begin
            h = Q30_ONE - (t2 * h) / (Q30_ONE * divisor[i]);
        end
        if (h < 0)
        begin
            h = 0;
        end
        if (h > Q30_ONE)
        begin
            h = Q30_ONE;
        end
        return (Q30_ONE - h + 64'sd16384) >>> 15;
    endfunction

    function automatic logic [127:0] cosine_weight(input logic [16:0] m);
        longint x;
        x = longint'((m >> TBL_SHIFT) << TBL_SHIFT);
        if (x <= 32768)
        begin
            return 128'(half_cosine(x));
        end
        return 128'(65536 - half_cosine(65536 - x));
    endfunction

    // Rounded blend of start, control and end with weights summing to 2^32
    function automatic logic signed [31:0] interpolate(input kvi_pkg::mode_t md,
                                                       input logic [31:0] sv,
                                                       input logic [31:0] ev,
                                                       input logic [31:0] cp,
                                                       input logic [16:0] frac);
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  c;
        logic [16:0]  m;
        logic [127:0] w0;
        logic [127:0] w1;
        logic [127:0] w2;
        logic [127:0] n;
        logic [127:0] total;
        a  = sv ^ BIAS;
        b  = ev ^ BIAS;
        c  = cp ^ BIAS;
        m  = (frac > FRAC_ONE) ? FRAC_ONE : frac;
        w1 = '0;
        case (md)
            kvi_pkg::MODE_HOLD:
            begin
                w2 = '0;
            end
            kvi_pkg::MODE_LINEAR:
            begin
                w2 = 128'(m) << 16;
            end
            kvi_pkg::MODE_COSINE:
            begin
                w2 = cosine_weight(m) << 16;
            end
            default:
            begin
                w2 = 128'(m) * 128'(m);
            end
        endcase
        w0 = (128'(1) << 32) - w2;
        if (md == kvi_pkg::MODE_BEZIER)
        begin
            n  = 128'(FRAC_ONE) - 128'(m);
            w0 = n * n;
            w1 = 128'(2) * 128'(m) * n;
        end
        total = 128'(a) * w0 + 128'(c) * w1 + 128'(b) * w2 + 128'(BIAS);
        return total[63:32] ^ BIAS;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    // Drive one command beat and hold it until taken
    task automatic send_beat(input kvi_pkg::mode_t md, input logic [31:0] sv,
                             input logic [31:0] ev, input logic [31:0] cp,
                             input logic [16:0] frac);
        while (idle_en && $urandom_range(99) < 6)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        mode          <= md;
        start_value   <= sv;
        end_value     <= ev;
        control_point <= cp;
        fraction      <= frac;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_values.push_back(interpolate(md, sv, ev, cp, frac));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return 32'($urandom_range(255)) - 32'd128;
            3:       return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] pick_fraction();
        case ($urandom_range(15))
            0:       return '0;
            1:       return FRAC_ONE;
            2:       return FRAC_ONE + 17'($urandom_range(65535)) + 17'd1;
            3:       return FRAC_HALF + 17'($urandom_range(2)) - 17'd1;
            4:       return 17'($urandom);
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_values.size() == 0)
            begin
                report_mismatch("unexpected value", value, 'x);
            end
            else
            begin
                if (value !== pending_values[0])
                begin
                    report_mismatch("value", value, pending_values[0]);
                end
                void'(pending_values.pop_front());
            end
        end
    end

    task automatic test_hold();
        send_beat(kvi_pkg::MODE_HOLD, VAL_MIN, VAL_MAX, VAL_MAX, FRAC_ONE);
        send_beat(kvi_pkg::MODE_HOLD, VAL_MAX, VAL_MIN, VAL_MIN, FRAC_HALF);
        send_beat(kvi_pkg::MODE_HOLD, 32'h0001_8000, 32'h1234_5678, 32'hDEAD_BEEF, '0);
    endtask

    task automatic test_linear();
        send_beat(kvi_pkg::MODE_LINEAR, VAL_MIN, VAL_MAX, VAL_MAX, '0);
        send_beat(kvi_pkg::MODE_LINEAR, VAL_MIN, VAL_MAX, VAL_MIN, FRAC_ONE);
        send_beat(kvi_pkg::MODE_LINEAR, VAL_MIN, VAL_MAX, '0, FRAC_HALF);
        send_beat(kvi_pkg::MODE_LINEAR, 32'h0000_0001, 32'h0000_0002, VAL_MAX, FRAC_HALF);
        send_beat(kvi_pkg::MODE_LINEAR, 32'hFFFF_0000, 32'hFFFF_0000, VAL_MIN, 17'h0_5555);
    endtask

    task automatic test_cosine();
        send_beat(kvi_pkg::MODE_COSINE, VAL_MAX, VAL_MIN, VAL_MIN, '0);
        send_beat(kvi_pkg::MODE_COSINE, VAL_MAX, VAL_MIN, VAL_MAX, FRAC_ONE);
        send_beat(kvi_pkg::MODE_COSINE, VAL_MIN, VAL_MAX, '0, FRAC_HALF);
        // below one table step the weight stays at zero
        send_beat(kvi_pkg::MODE_COSINE, VAL_MIN, VAL_MAX, '0, 17'h0_003F);
        send_beat(kvi_pkg::MODE_COSINE, VAL_MIN, VAL_MAX, '0, 17'h0_FFFF);
        send_beat(kvi_pkg::MODE_COSINE, VAL_MIN, VAL_MAX, '0, 17'h0_8040);
    endtask

    task automatic test_bezier();
        send_beat(kvi_pkg::MODE_BEZIER, VAL_MIN, VAL_MAX, VAL_MAX, '0);
        send_beat(kvi_pkg::MODE_BEZIER, VAL_MIN, VAL_MAX, VAL_MIN, FRAC_ONE);
        send_beat(kvi_pkg::MODE_BEZIER, VAL_MIN, VAL_MIN, VAL_MAX, FRAC_HALF);
        send_beat(kvi_pkg::MODE_BEZIER, VAL_MAX, VAL_MAX, VAL_MIN, 17'h0_0001);
    endtask

    task automatic test_saturation();
        send_beat(kvi_pkg::MODE_LINEAR, VAL_MIN, VAL_MAX, '0, FRAC_ONE + 17'd1);
        send_beat(kvi_pkg::MODE_COSINE, VAL_MAX, VAL_MIN, '0, FRAC_TOP);
        send_beat(kvi_pkg::MODE_BEZIER, 32'h0F0F_0F0F, 32'hF0F0_F0F0, VAL_MAX, 17'h1_8000);
    endtask

    task automatic test_random(input int count);
        kvi_pkg::mode_t md;
        for (int i = 0; i < count; i++)
        begin
            // hold a long run back to back
            idle_en = !(i >= count / 3 && i < count / 2);
            md = kvi_pkg::mode_t'($urandom_range(3));
            send_beat(md, pick_value(), pick_value(), pick_value(), pick_fraction());
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = kvi_pkg::MODE_HOLD;
        start_value    = '0;
        end_value      = '0;
        control_point  = '0;
        fraction       = '0;
        mismatch_count = 0;
        idle_en        = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hold();
        test_linear();
        test_cosine();
        test_bezier();
        test_saturation();
        test_random(2000);
        start <= 1'b0;
        while (pending_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatch_count == 0 && pending_values.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
